// ===== design/tce_pkg.sv =====
// Shared constants, codes and control structs of the text console engine.
package tce_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CELL_AW    = $clog2(CELL_COUNT);
   localparam int COPY_END   = CELL_COUNT - COLUMNS;

   localparam int OP_W     = 3;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CURSOR_W = 11;
   localparam int ADDR_W   = 11;
   localparam int CELL_W   = 16;
   localparam int ADV_W    = CURSOR_W + 1;

   // row = (addr * ROW_RECIP) >> ROW_SHIFT, exact for every ADDR_W-bit address
   localparam int ROW_SHIFT = ADDR_W + $clog2(COLUMNS);
   localparam int ROW_RECIP = (1 << ROW_SHIFT) / COLUMNS + 1;
   localparam int PROD_W    = ADDR_W + ROW_SHIFT;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [OP_W-1:0] OP_PRINT      = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT        = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

   localparam logic REG_ATTRIBUTE = 1'b0;

   typedef struct packed {
      logic load;
      logic write_first;
      logic write_second;
      logic advance;
      logic set_cursor;
      logic read;
      logic copy_step;
      logic fill_step;
      logic clear_step;
      logic init_step;
      logic respond;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_newline;
      logic            is_tab;
      logic            addr_bad;
      logic            overflow;
      logic            copy_last;
      logic            sweep_last;
      logic            out_free;
   } dp_status_type;

endpackage

// ===== design/tce_datapath.sv =====
// Datapath: screen memory, cursor and column arithmetic, sweep counter, result register.
module tce_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tce_pkg::OP_W-1:0]        req_op,
   input  logic [tce_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tce_pkg::ADDR_W-1:0]      req_address,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tce_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [tce_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [tce_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready,
   input  tce_pkg::dp_cmd_type             cmd,
   output tce_pkg::dp_status_type          status,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tce_pkg::CURSOR_W-1:0]    rsp_cursor_pos,
   output logic [tce_pkg::CELL_W-1:0]      rsp_cell_value,
   output logic                            rsp_scrolled,
   output logic                            rsp_error
);
   import tce_pkg::*;

   localparam logic [ADV_W-1:0]    CELL_LIMIT    = ADV_W'(CELL_COUNT);
   localparam logic [ADV_W-1:0]    COLS_EXT      = ADV_W'(COLUMNS);
   localparam logic [CURSOR_W-1:0] COLS_NARROW   = CURSOR_W'(COLUMNS);
   localparam logic [PROD_W-1:0]   ROW_RECIP_EXT = PROD_W'(ROW_RECIP);
   localparam logic [CELL_AW-1:0]  COPY_LAST     = CELL_AW'(COPY_END);
   localparam logic [CELL_AW-1:0]  SWEEP_LAST    = CELL_AW'(CELL_COUNT - 1);

   logic [OP_W-1:0]     op_ff;
   logic [CHAR_W-1:0]   ch_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [CURSOR_W-1:0] col_ff, col_in;
   logic [ATTR_W-1:0]   attr_ff;
   logic [CELL_AW-1:0]  idx_ff, idx_in;
   logic                scrolled_ff;
   logic [CELL_W-1:0]   rd_data_ff;
   logic [CELL_W-1:0]   screen_ff [CELL_COUNT];
   logic                rsp_valid_ff;
   logic [CURSOR_W-1:0] rsp_cursor_ff;
   logic [CELL_W-1:0]   rsp_cell_ff;
   logic                rsp_scrolled_ff;
   logic                rsp_error_ff;

   logic                csr_write;
   logic [CURSOR_W-1:0] base;
   logic [ADV_W-1:0]    base1;
   logic                second_ok;
   logic [ADV_W-1:0]    inc;
   logic [ADV_W-1:0]    adv;
   logic                overflow;
   logic [ADV_W-1:0]    col_adv;
   logic [PROD_W-1:0]   row_prod;
   logic [CURSOR_W-1:0] set_row;
   logic [CURSOR_W-1:0] set_col;
   logic                mem_we;
   logic [CELL_AW-1:0]  mem_waddr;
   logic [CELL_W-1:0]   mem_wdata;
   logic                mem_re;
   logic [CELL_AW-1:0]  mem_raddr;
   logic [CELL_AW:0]    copy_src;
   logic                addr_used;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ATTRIBUTE) ? CSR_DW'(attr_ff) : '0;

   assign status.op         = op_ff;
   assign status.is_newline = (ch_ff == CH_NEWLINE);
   assign status.is_tab     = (ch_ff == CH_TAB);
   assign status.addr_bad   = ({1'b0, addr_ff} >= CELL_LIMIT);
   assign status.overflow   = overflow;
   assign status.copy_last  = (idx_ff == COPY_LAST);
   assign status.sweep_last = (idx_ff == SWEEP_LAST);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign base      = (op_ff == OP_PRINT) ? cursor_ff : addr_ff;
   assign base1     = {1'b0, base} + ADV_W'(1);
   assign second_ok = (base1 < CELL_LIMIT);

   always_comb begin
      inc     = status.is_tab ? ADV_W'(2) : ADV_W'(1);
      adv     = status.is_newline ? ({1'b0, cursor_ff} - {1'b0, col_ff} + COLS_EXT)
                                  : ({1'b0, cursor_ff} + inc);
      overflow  = (adv >= CELL_LIMIT);
      cursor_in = overflow ? CURSOR_W'(adv - COLS_EXT) : adv[CURSOR_W-1:0];
      col_adv = {1'b0, col_ff} + inc;
      if (status.is_newline) begin
         col_in = '0;
      end else if (col_adv >= COLS_EXT) begin
         col_in = CURSOR_W'(col_adv - COLS_EXT);
      end else begin
         col_in = col_adv[CURSOR_W-1:0];
      end
   end

   // column of a new cursor address by reciprocal multiplication
   assign row_prod = PROD_W'(addr_ff) * ROW_RECIP_EXT;
   assign set_row  = CURSOR_W'(row_prod >> ROW_SHIFT);
   assign set_col  = addr_ff - set_row * COLS_NARROW;

   assign copy_src = {1'b0, idx_ff} + (CELL_AW + 1)'(COLUMNS);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      priority if (cmd.init_step) begin
         mem_we = 1'b1;
      end else if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_wdata = {attr_ff, 8'd0};
      end else if (cmd.fill_step) begin
         mem_we    = 1'b1;
         mem_wdata = {attr_ff, CH_SPACE};
      end else if (cmd.copy_step) begin
         mem_we    = (idx_ff != '0);
         mem_waddr = idx_ff - CELL_AW'(1);
         mem_wdata = rd_data_ff;
      end else if (cmd.write_first) begin
         mem_we    = 1'b1;
         mem_waddr = CELL_AW'(base);
         mem_wdata = {attr_ff, status.is_tab ? CH_SPACE : ch_ff};
      end else if (cmd.write_second) begin
         mem_we    = second_ok;
         mem_waddr = CELL_AW'(base1);
         mem_wdata = {attr_ff, CH_SPACE};
      end else begin
         mem_we = 1'b0;
      end
   end

   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = CELL_AW'(addr_ff);
      if (cmd.read) begin
         mem_re = 1'b1;
      end else if (cmd.copy_step) begin
         mem_re    = !status.copy_last;
         mem_raddr = copy_src[CELL_AW-1:0];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.init_step || cmd.clear_step || cmd.fill_step) begin
         idx_in = idx_ff + CELL_AW'(1);
      end else if (cmd.copy_step && !status.copy_last) begin
         idx_in = idx_ff + CELL_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_ff[mem_raddr];
      end
   end

   assign addr_used = (op_ff == OP_PUT) || (op_ff == OP_SET_CURSOR) || (op_ff == OP_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         idx_ff       <= '0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (csr_write && csr_paddr[2] == REG_ATTRIBUTE) begin
            attr_ff <= csr_pwdata[ATTR_W-1:0];
         end
         if (cmd.load) begin
            scrolled_ff <= 1'b0;
         end else if (cmd.advance && overflow) begin
            scrolled_ff <= 1'b1;
         end
         if (cmd.advance) begin
            cursor_ff <= cursor_in;
            col_ff    <= col_in;
         end else if (cmd.set_cursor) begin
            cursor_ff <= addr_ff;
            col_ff    <= set_col;
         end
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         ch_ff   <= req_char_code;
         addr_ff <= req_address;
      end
      if (cmd.respond) begin
         rsp_cursor_ff   <= cursor_ff;
         rsp_cell_ff     <= (op_ff == OP_READ && !status.addr_bad) ? rd_data_ff : '0;
         rsp_scrolled_ff <= scrolled_ff;
         rsp_error_ff    <= addr_used && status.addr_bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_error      = rsp_error_ff;

endmodule

// ===== design/tce_controller.sv =====
// Controller: sequences each op, the scroll and clear sweeps and the clearing pass after reset.
module tce_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tce_pkg::dp_status_type status,
   output tce_pkg::dp_cmd_type    cmd
);
   import tce_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_TAB2,
      ST_COPY,
      ST_FILL,
      ST_CLEAR,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESPOND;
            unique case (status.op)
               OP_PRINT: begin
                  if (status.is_newline) begin
                     cmd.advance = 1'b1;
                     if (status.overflow) state_in = ST_COPY;
                  end else if (status.is_tab) begin
                     cmd.write_first = 1'b1;
                     state_in        = ST_TAB2;
                  end else begin
                     cmd.write_first = 1'b1;
                     cmd.advance     = 1'b1;
                     if (status.overflow) state_in = ST_COPY;
                  end
               end
               OP_PUT: begin
                  if (!status.addr_bad && !status.is_newline) begin
                     cmd.write_first = 1'b1;
                     if (status.is_tab) state_in = ST_TAB2;
                  end
               end
               OP_CLEAR: state_in = ST_CLEAR;
               OP_SET_CURSOR: cmd.set_cursor = !status.addr_bad;
               OP_READ: cmd.read = !status.addr_bad;
               default: state_in = ST_RESPOND;
            endcase
         end
         ST_TAB2: begin
            cmd.write_second = 1'b1;
            state_in         = ST_RESPOND;
            if (status.op == OP_PRINT) begin
               cmd.advance = 1'b1;
               if (status.overflow) state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.sweep_last) state_in = ST_RESPOND;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== design/text_console_engine_unit.sv =====
// Text console engine top level: controller plus datapath.
// The result word is registered in the respond state, after the execute state (and the second tab state for a tab).
// One word is in flight, so the next word is accepted only after the result loads.
// A scroll adds a copy sweep (copy pipeline over one memory port), then a row of spaces;
// clear adds a sweep over every cell. A stalled result word holds the input stalled.
// Synchronous reset; the screen is then zeroed one cell per cycle, with req_stall high.
module text_console_engine_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tce_pkg::OP_W-1:0]        req_op,
   input  logic [tce_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tce_pkg::ADDR_W-1:0]      req_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tce_pkg::CURSOR_W-1:0]    rsp_cursor_pos,
   output logic [tce_pkg::CELL_W-1:0]      rsp_cell_value,
   output logic                            rsp_scrolled,
   output logic                            rsp_error,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tce_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [tce_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [tce_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import tce_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tce_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tce_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_char_code  (req_char_code),
      .req_address    (req_address),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_value (rsp_cell_value),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_error      (rsp_error)
   );

endmodule

// ===== design/tce_checker.sv =====
// Port-level checker for the text console engine and its bind.
module tce_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [tce_pkg::CURSOR_W-1:0] rsp_cursor_pos,
   input logic [tce_pkg::CELL_W-1:0]   rsp_cell_value,
   input logic                         rsp_scrolled,
   input logic                         rsp_error
);
   import tce_pkg::*;

   localparam logic [CURSOR_W-1:0] LAST_ROW = CURSOR_W'(CELL_COUNT - COLUMNS);
   localparam logic [CURSOR_W:0]   LIMIT    = (CURSOR_W + 1)'(CELL_COUNT);

   a_init_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not stalled during clearing pass");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_cursor_pos} < LIMIT))
      else $error("cursor off screen");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_scrolled && rsp_cell_value == '0)
      else $error("rejected word reports a scroll or a cell");

   a_scroll_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_pos >= LAST_ROW)
      else $error("scroll left cursor above last row");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_pos)
                                 && $stable(rsp_cell_value))
      else $error("stalled result changed");

endmodule

bind text_console_engine_unit tce_checker u_tce_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cursor_pos (rsp_cursor_pos),
   .rsp_cell_value (rsp_cell_value),
   .rsp_scrolled   (rsp_scrolled),
   .rsp_error      (rsp_error)
);

// ===== sim/tb_text_console_engine_unit.sv =====
// Self-checking testbench for the text console engine: directed cases, random traffic, checker.
module tb_text_console_engine_unit;
   import tce_pkg::*;

   localparam int IDLE_LIMIT     = 20000;
   localparam int DRAIN_CYCLES   = 2100;
   localparam int LONG_HOLD      = 400;
   localparam int PHASE_WORDS    = 250;
   localparam int LAST_CELL      = CELL_COUNT - 1;
   localparam int OFF_SCREEN_MAX = (1 << ADDR_W) - 1;

   localparam logic [ADDR_W-1:0] LAST_CELL_ADDR = ADDR_W'(LAST_CELL);
   localparam logic [ADDR_W-1:0] FIRST_OFF_ADDR = ADDR_W'(CELL_COUNT);
   localparam logic [ADDR_W-1:0] LAST_OFF_ADDR  = ADDR_W'(OFF_SCREEN_MAX);

   localparam logic [OP_W-1:0]   OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0]   OP_UNUSED_LAST  = 3'd7;
   localparam logic [CSR_AW-1:0] ATTR_ADDR       = CSR_AW'(4 * int'(REG_ATTRIBUTE));

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_pos;
      logic [CELL_W-1:0]   cell_value;
      logic                scrolled;
      logic                error;
   } console_reply_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op        = '0;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic [ADDR_W-1:0]   req_address   = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [CURSOR_W-1:0] rsp_cursor_pos;
   logic [CELL_W-1:0]   rsp_cell_value;
   logic                rsp_scrolled;
   logic                rsp_error;
   logic                csr_psel      = 1'b0;
   logic                csr_penable   = 1'b0;
   logic                csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr     = '0;
   logic [CSR_DW-1:0]   csr_pwdata    = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // predictor state
   logic [CELL_W-1:0]   screen_model [CELL_COUNT];
   int unsigned         cursor_model;
   logic [ATTR_W-1:0]   attr_model;
   console_reply_type   pending_replies [$];

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int holds_asked   = 0;
   int holds_taken   = 0;
   int idle_cycles   = 0;
   int mismatches    = 0;
   int words_sent    = 0;
   int replies_checked = 0;
   int scrolls_predicted = 0;
   int errors_predicted  = 0;
   int clears_sent   = 0;
   int attr_writes   = 0;

   text_console_engine_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void store_char(int unsigned where, logic [CHAR_W-1:0] ch);
      if (where < CELL_COUNT) screen_model[where] = {attr_model, ch};
   endfunction

   function automatic void place_char(int unsigned where, logic [CHAR_W-1:0] ch);
      if (ch == CH_NEWLINE) return;
      if (ch == CH_TAB) begin
         store_char(where, CH_SPACE);
         store_char(where + 1, CH_SPACE);
      end else begin
         store_char(where, ch);
      end
   endfunction

   function automatic console_reply_type console_step(logic [OP_W-1:0] op,
                                                      logic [CHAR_W-1:0] ch,
                                                      logic [ADDR_W-1:0] addr);
      console_reply_type r;
      r = '0;
      case (op)
         OP_PRINT: begin
            if (ch == CH_NEWLINE) begin
               cursor_model = (cursor_model / COLUMNS + 1) * COLUMNS;
            end else begin
               place_char(cursor_model, ch);
               cursor_model += (ch == CH_TAB) ? 2 : 1;
            end
            if (cursor_model / COLUMNS >= ROWS) begin
               for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                  screen_model[i] = screen_model[i + COLUMNS];
               for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  screen_model[i] = {attr_model, CH_SPACE};
               cursor_model = (ROWS - 1) * COLUMNS + cursor_model % COLUMNS;
               r.scrolled = 1'b1;
               scrolls_predicted++;
            end
         end
         OP_PUT: begin
            if (addr >= CELL_COUNT) r.error = 1'b1;
            else place_char(32'(addr), ch);
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {attr_model, 8'h00};
            clears_sent++;
         end
         OP_SET_CURSOR: begin
            if (addr >= CELL_COUNT) r.error = 1'b1;
            else cursor_model = 32'(addr);
         end
         OP_READ: begin
            if (addr >= CELL_COUNT) r.error = 1'b1;
            else r.cell_value = screen_model[addr];
         end
         default: ;
      endcase
      if (r.error) errors_predicted++;
      r.cursor_pos = CURSOR_W'(cursor_model);
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch on %s: got %0h, want %0h (reply %0d)",
                  what, got, want, replies_checked);
   endtask

   // reply checker
   always @(posedge clock) begin : reply_check
      console_reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_replies.size() == 0) begin
            flag_mismatch("unexpected reply word", 32'(rsp_cursor_pos), 32'd0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_cursor_pos !== want.cursor_pos)
               flag_mismatch("cursor_pos", 32'(rsp_cursor_pos), 32'(want.cursor_pos));
            if (rsp_cell_value !== want.cell_value)
               flag_mismatch("cell_value", 32'(rsp_cell_value), 32'(want.cell_value));
            if (rsp_scrolled !== want.scrolled)
               flag_mismatch("scrolled", 32'(rsp_scrolled), 32'(want.scrolled));
            if (rsp_error !== want.error)
               flag_mismatch("error", 32'(rsp_error), 32'(want.error));
         end
         replies_checked++;
      end
   end

   // receiver: random stalls, plus a long hold each time one is asked for
   always @(posedge clock) begin : receiver
      if (rsp_hold_left > 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (holds_taken != holds_asked) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left <= LONG_HOLD - 1;
         holds_taken   <= holds_asked;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_char_code <= ch;
      req_address   <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_replies.push_back(console_step(op, ch, addr));
      words_sent++;
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // write then read back the attribute register; only called with nothing in flight
   task automatic set_attribute(logic [ATTR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ATTR_ADDR;
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      attr_model = value;
      attr_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[ATTR_W-1:0] !== value)
         flag_mismatch("attribute readback", csr_prdata, 32'(value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_random_word(output bit useful);
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] ch;
      logic [ADDR_W-1:0] addr;
      int                roll;
      roll = $urandom_range(99);
      ch   = CHAR_W'($urandom_range(255));
      addr = ADDR_W'($urandom_range(LAST_CELL));
      if (roll < 45) begin
         op = OP_PRINT;
         case ($urandom_range(9))
            0: ch = CH_NEWLINE;
            1: ch = CH_TAB;
            default: ;
         endcase
      end else if (roll < 60) begin
         op = OP_PUT;
         case ($urandom_range(9))
            0: ch = CH_NEWLINE;
            1: ch = CH_TAB;
            default: ;
         endcase
         if ($urandom_range(4) == 0) addr = ADDR_W'($urandom_range(LAST_CELL, LAST_CELL - 1));
      end else if (roll < 62) begin
         op = OP_CLEAR;
      end else if (roll < 74) begin
         op = OP_SET_CURSOR;
         if ($urandom_range(1))
            addr = ADDR_W'($urandom_range(LAST_CELL, LAST_CELL - 2 * COLUMNS));
      end else if (roll < 97) begin
         op = OP_READ;
         if ($urandom_range(1))
            addr = ADDR_W'((cursor_model + CELL_COUNT - $urandom_range(3)) % CELL_COUNT);
      end else begin
         op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      end
      if ((op == OP_PUT || op == OP_SET_CURSOR || op == OP_READ) && $urandom_range(9) == 0)
         addr = ADDR_W'($urandom_range(OFF_SCREEN_MAX, CELL_COUNT));
      useful = (op < OP_UNUSED_FIRST) &&
               !((op == OP_PUT || op == OP_SET_CURSOR || op == OP_READ) && addr >= CELL_COUNT);
      send_word(op, ch, addr);
   endtask

   task automatic test_reset_contents();
      send_word(OP_READ, 8'h00, 11'd0);
      send_word(OP_READ, 8'hff, LAST_CELL_ADDR);
      send_word(OP_PRINT, 8'h41, 11'd0);
      send_word(OP_READ, 8'h00, 11'd0);
   endtask

   task automatic test_print_cases();
      send_word(OP_PRINT, 8'h00, 11'd0);
      send_word(OP_PRINT, 8'hff, 11'd0);
      send_word(OP_PRINT, CH_NEWLINE, 11'd0);
      send_word(OP_PRINT, CH_TAB, 11'd0);
      // wrap past the last cell
      send_word(OP_SET_CURSOR, 8'h00, LAST_CELL_ADDR);
      send_word(OP_PRINT, 8'h78, 11'd0);
      // tab in the last cell drops its second space
      send_word(OP_SET_CURSOR, 8'h00, LAST_CELL_ADDR);
      send_word(OP_PRINT, CH_TAB, 11'd0);
      send_word(OP_SET_CURSOR, 8'h00, LAST_CELL_ADDR - 11'd1);
      send_word(OP_PRINT, CH_TAB, 11'd0);
      send_word(OP_SET_CURSOR, 8'h00, LAST_CELL_ADDR - 11'd49);
      send_word(OP_PRINT, CH_NEWLINE, 11'd0);
      send_word(OP_READ, 8'h00, LAST_CELL_ADDR);
   endtask

   task automatic test_put_and_bad_addresses();
      send_word(OP_PUT, 8'hff, 11'd0);
      send_word(OP_PUT, CH_TAB, LAST_CELL_ADDR);
      send_word(OP_PUT, CH_TAB, LAST_CELL_ADDR - 11'd1);
      send_word(OP_PUT, CH_NEWLINE, 11'd5);
      send_word(OP_PUT, 8'h55, FIRST_OFF_ADDR);
      send_word(OP_PUT, 8'haa, LAST_OFF_ADDR);
      send_word(OP_SET_CURSOR, 8'h00, FIRST_OFF_ADDR);
      send_word(OP_READ, 8'h00, LAST_OFF_ADDR);
      send_word(OP_UNUSED_LAST, 8'hff, LAST_OFF_ADDR);
   endtask

   task automatic test_clear_fill();
      drain_replies();
      set_attribute(8'ha5);
      send_word(OP_CLEAR, 8'h00, 11'd0);
      send_word(OP_READ, 8'h00, LAST_CELL_ADDR);
   endtask

   task automatic test_random_phase(int gap_pct, int stall_pct, logic [ATTR_W-1:0] attr);
      int useful_words;
      bit useful;
      useful_words = 0;
      drain_replies();
      set_attribute(attr);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      while (useful_words < PHASE_WORDS) begin
         send_random_word(useful);
         if (useful) useful_words++;
      end
   endtask

   task automatic test_long_backpressure();
      bit useful;
      send_gap_pct = 0;
      holds_asked++;
      repeat (12) send_random_word(useful);
   endtask

   initial begin
      for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = '0;
      cursor_model = 0;
      attr_model   = ATTR_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct  = 10;
      rsp_stall_pct = 10;
      test_reset_contents();
      test_print_cases();
      test_put_and_bad_addresses();
      test_clear_fill();
      test_random_phase(24, 80, 8'h00);
      test_random_phase(80, 24, 8'hff);
      test_random_phase(0, 0, ATTR_W'($urandom_range(255)));
      test_long_backpressure();
      drain_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d words: %0d scrolls, %0d off-screen errors, %0d clears",
               words_sent, scrolls_predicted, errors_predicted, clears_sent);
      $display("%0d attribute settings, %0d replies checked, %0d mismatches",
               attr_writes, replies_checked, mismatches);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
